// File: sv/lgts_pkg.sv
package lgts_pkg;

    localparam int GRID_WIDTH_DEF  = 32;
    localparam int GRID_HEIGHT_DEF = 16;

    localparam int CMD_W = 2;
    localparam int COL_W = 5;
    localparam int ROW_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_FETCH,
        S_MODIFY,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

// File: sv/life_grid_toroidal_step.sv
// One command at a time; a step sweeps the row memory through one row-update unit,
// a row per cycle; the next command waits until the result enters the output register.
// Reset (i_rst_n low, synchronous) clears the per-row valid bits, so every cell reads
// dead right after reset; there is no clearing pass. Clear uses the same valid bits.
module life_grid_toroidal_step
    import lgts_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [COL_W-1:0] i_col_x,
    input  logic [ROW_W-1:0] i_row_y,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_cell_alive
);

    localparam int AW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
    localparam int CW = $clog2(GRID_HEIGHT + 3);

    typedef logic [GRID_WIDTH-1:0] t_row;

    // one generation for a row, given the rows above and below (columns wrap)
    function automatic t_row life_row(t_row up, t_row mid, t_row dn);
        t_row       res;
        t_row       up_l, up_r, mid_l, mid_r, dn_l, dn_r;
        logic [3:0] n;
        up_l  = (up  << 1) | (up  >> (GRID_WIDTH - 1));
        up_r  = (up  >> 1) | (up  << (GRID_WIDTH - 1));
        mid_l = (mid << 1) | (mid >> (GRID_WIDTH - 1));
        mid_r = (mid >> 1) | (mid << (GRID_WIDTH - 1));
        dn_l  = (dn  << 1) | (dn  >> (GRID_WIDTH - 1));
        dn_r  = (dn  >> 1) | (dn  << (GRID_WIDTH - 1));
        for (int x = 0; x < GRID_WIDTH; x++) begin
            n = {3'b0, up_l[x]} + {3'b0, up[x]} + {3'b0, up_r[x]}
              + {3'b0, mid_l[x]} + {3'b0, mid_r[x]}
              + {3'b0, dn_l[x]} + {3'b0, dn[x]} + {3'b0, dn_r[x]};
            res[x] = (n == 4'd3) || (mid[x] && (n == 4'd2));
        end
        return res;
    endfunction

    function automatic logic pick(t_row r, logic [COL_W-1:0] x);
        t_row s;
        s = r >> x;
        return s[0];
    endfunction

    t_state           r_state, n_state;
    t_cmd             r_cmd;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_in_grid;
    logic [CW-1:0]    r_cnt;

    t_row             mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] r_valid;
    t_row             r_rd_data;
    logic             r_rd_vld;

    t_row             r_win_a, r_win_b, r_row0;
    logic             r_result;
    logic             r_out_valid, r_out_data;

    logic             in_xfer, out_free, in_grid;
    t_row             rd_row, cur_row, next_row;
    logic             mem_we, clr_valid;
    logic [AW-1:0]    mem_raddr, mem_waddr;
    t_row             mem_wdata;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign in_grid  = (int'(i_col_x) < GRID_WIDTH) && (int'(i_row_y) < GRID_HEIGHT);

    // rows never written since reset or clear read as dead
    assign rd_row   = r_rd_vld ? r_rd_data : '0;
    // the last row's lower neighbor is the saved original of row 0
    assign cur_row  = (r_cnt == CW'(GRID_HEIGHT + 2)) ? r_row0 : rd_row;
    assign next_row = life_row(r_win_b, r_win_a, cur_row);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_STEP:  n_state = S_STEP;
                        CMD_SET:   n_state = S_FETCH;
                        CMD_READ:  n_state = S_FETCH;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_STEP: begin
                if (r_cnt == CW'(GRID_HEIGHT + 2)) n_state = S_DONE;
            end
            S_FETCH:  n_state = S_MODIFY;
            S_MODIFY: n_state = S_DONE;
            S_CLEAR:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        mem_we    = 1'b0;
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = '0;
        clr_valid = 1'b0;
        unique case (r_state)
            S_STEP: begin
                // read last row, then rows 0..last; write row (cnt-3) from cnt 3 on
                if (r_cnt == '0) begin
                    mem_raddr = AW'(GRID_HEIGHT - 1);
                end else if (r_cnt <= CW'(GRID_HEIGHT)) begin
                    mem_raddr = AW'(r_cnt - CW'(1));
                end
                if (r_cnt >= CW'(3)) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_cnt - CW'(3));
                    mem_wdata = next_row;
                end
            end
            S_FETCH: mem_raddr = AW'(r_row);
            S_MODIFY: begin
                if (r_cmd == CMD_SET && r_in_grid) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_row);
                    mem_wdata = rd_row | (t_row'(1) << r_col);
                end
            end
            S_CLEAR: clr_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd_data <= mem[mem_raddr];
        r_rd_vld  <= r_valid[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_valid) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (in_xfer) begin
                r_cnt <= '0;
            end else if (r_state == S_STEP) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_col     <= i_col_x;
            r_row     <= i_row_y;
            r_in_grid <= in_grid;
            r_result  <= 1'b0;
        end
        if (r_state == S_STEP) begin
            r_win_b <= r_win_a;
            r_win_a <= cur_row;
            if (r_cnt == CW'(2)) r_row0 <= cur_row;
            if (mem_we && r_in_grid && mem_waddr == AW'(r_row)) begin
                r_result <= pick(next_row, r_col);
            end
        end
        if (r_state == S_MODIFY) begin
            r_result <= r_in_grid && ((r_cmd == CMD_SET) || pick(rd_row, r_col));
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data <= r_result;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_out_data;

endmodule

// File: sv/lgts_checker.sv
module lgts_checker
    import lgts_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic [CMD_W-1:0] i_cmd,
    input logic [COL_W-1:0] i_col_x,
    input logic [ROW_W-1:0] i_row_y,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_cell_alive
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cell_alive))
        else $error("result dropped or changed while stalled");

    // busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready again right after a transfer");

    // a new result only appears at the end of a busy period
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a command in progress");

    // nothing pending out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind life_grid_toroidal_step lgts_checker u_lgts_checker (.*);

// File: sim/tb.sv
module tb
    import lgts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW             = GRID_WIDTH_DEF;
    localparam int GH             = GRID_HEIGHT_DEF;
    localparam int PHASE_A_END    = 600;
    localparam int PHASE_B_END    = 1200;
    localparam int ITEM_TARGET    = 1725;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = GH + 12;

    typedef struct {
        logic             alive;
        t_cmd             cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_cell_expectation;

    // Tracks the grid on the side and queues the cell state each command should report.
    class life_scoreboard;
        logic [GW-1:0]     grid [GH];
        t_cell_expectation pending_q[$];
        int                mismatches;
        int                results_seen;
        int                live_seen;
        int                cmd_count [4];

        function new();
            foreach (grid[r]) grid[r] = '0;
            foreach (cmd_count[k]) cmd_count[k] = 0;
            mismatches   = 0;
            results_seen = 0;
            live_seen    = 0;
        endfunction

        function void note_command(t_cmd c, logic [COL_W-1:0] x, logic [ROW_W-1:0] y);
            logic [GW-1:0]     nxt [GH];
            int                n;
            t_cell_expectation e;
            case (c)
                CMD_STEP: begin
                    for (int r = 0; r < GH; r++) begin
                        for (int k = 0; k < GW; k++) begin
                            n = 0;
                            // wrap both axes, diagonals included
                            for (int dr = -1; dr <= 1; dr++)
                                for (int dk = -1; dk <= 1; dk++)
                                    if (dr != 0 || dk != 0)
                                        n += grid[(r + dr + GH) % GH][(k + dk + GW) % GW];
                            nxt[r][k] = grid[r][k] ? (n == 2 || n == 3) : (n == 3);
                        end
                    end
                    grid = nxt;
                end
                CMD_SET:   grid[y][x] = 1'b1;
                CMD_CLEAR: foreach (grid[r]) grid[r] = '0;
                default: ;
            endcase
            cmd_count[int'(c)]++;
            e.alive = grid[y][x];
            e.cmd   = c;
            e.col   = x;
            e.row   = y;
            pending_q.push_back(e);
        endfunction

        function void check_result(logic actual);
            t_cell_expectation e;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing pending: expected none, actual cell_alive %0b",
                         $time, actual);
                return;
            end
            e = pending_q.pop_front();
            if (actual !== e.alive) begin
                mismatches++;
                $display("%0t: %s col %0d row %0d: expected cell_alive %0b, actual %0b",
                         $time, e.cmd.name(), e.col, e.row, e.alive, actual);
            end else if (actual) begin
                live_seen++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [CMD_W-1:0] i_cmd;
    logic [COL_W-1:0] i_col_x;
    logic [ROW_W-1:0] i_row_y;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_cell_alive;

    life_scoreboard sb = new();

    int items_sent  = 0;
    int tx_idle_pct = 11;
    int rx_idle_pct = 52;
    int quiet_cycles = 0;
    bit hold_req    = 1'b0;

    life_grid_toroidal_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_col_x      (i_col_x),
        .i_row_y      (i_row_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_alive (o_cell_alive)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offer one command and return at the edge where its transfer happens.
    task automatic send_cmd(t_cmd c, int x, int y);
        if (items_sent == PHASE_B_END) hold_req = 1'b1;
        tx_idle_pct = (items_sent < PHASE_A_END) ? 11 : (items_sent < PHASE_B_END) ? 52 : 0;
        rx_idle_pct = (items_sent < PHASE_A_END) ? 52 : (items_sent < PHASE_B_END) ? 11 : 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= c;
        i_col_x    <= x[COL_W-1:0];
        i_row_y    <= y[ROW_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_command(c, x[COL_W-1:0], y[ROW_W-1:0]);
        items_sent++;
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_cell_alive);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int  ox;
        int  oy;
        int  span;
        bit  scatter;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = CMD_STEP;
        i_col_x    = '0;
        i_row_y    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty grid after reset, far corners
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_READ, GW - 1, GH - 1);
        send_cmd(CMD_STEP, 5, 5);
        // four corners form a block across both wraps: a still life
        send_cmd(CMD_SET, 0, 0);
        send_cmd(CMD_SET, GW - 1, GH - 1);
        send_cmd(CMD_SET, GW - 1, 0);
        send_cmd(CMD_SET, 0, GH - 1);
        send_cmd(CMD_STEP, GW - 1, 0);
        send_cmd(CMD_READ, 15, 7);
        send_cmd(CMD_CLEAR, 0, 0);
        send_cmd(CMD_READ, GW - 1, GH - 1);
        // blinker split across the column wrap
        send_cmd(CMD_SET, GW - 1, 8);
        send_cmd(CMD_SET, 0, 8);
        send_cmd(CMD_SET, 1, 8);
        send_cmd(CMD_STEP, 0, 7);
        send_cmd(CMD_READ, 0, 9);
        send_cmd(CMD_READ, GW - 1, 8);
        send_cmd(CMD_STEP, GW - 1, 8);
        // blinker split across the row wrap
        send_cmd(CMD_CLEAR, 10, 15);
        send_cmd(CMD_SET, 10, GH - 1);
        send_cmd(CMD_SET, 10, 0);
        send_cmd(CMD_SET, 10, 1);
        send_cmd(CMD_STEP, 9, 0);
        send_cmd(CMD_SET, 11, 0);
        // lone cell dies of isolation
        send_cmd(CMD_SET, 21, 10);
        send_cmd(CMD_STEP, 21, 10);

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(99) < 80) begin
                // seed a pattern on a fresh grid, then let it evolve
                send_cmd(CMD_CLEAR, $urandom_range(GW - 1), $urandom_range(GH - 1));
                span    = $urandom_range(3, 10);
                ox      = $urandom_range(GW - 1);
                oy      = $urandom_range(GH - 1);
                scatter = ($urandom_range(3) == 0);
                repeat ($urandom_range(3, span * span / 2 + 3)) begin
                    if (scatter)
                        send_cmd(CMD_SET, $urandom_range(GW - 1), $urandom_range(GH - 1));
                    else
                        send_cmd(CMD_SET, (ox + $urandom_range(span - 1)) % GW,
                                 (oy + $urandom_range(span - 1)) % GH);
                end
                repeat ($urandom_range(2, 12)) begin
                    send_cmd(CMD_STEP, (ox + $urandom_range(span + 1)) % GW,
                             (oy + $urandom_range(span + 1)) % GH);
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(1))
                            send_cmd(CMD_READ, $urandom_range(GW - 1), $urandom_range(GH - 1));
                        else
                            send_cmd(CMD_READ, (ox + $urandom_range(span)) % GW,
                                     (oy + $urandom_range(span)) % GH);
                    end
                end
            end else begin
                repeat ($urandom_range(1, 8))
                    send_cmd(t_cmd'($urandom_range(3)), $urandom_range(GW - 1),
                             $urandom_range(GH - 1));
            end
        end
        i_in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d steps, %0d sets, %0d clears, %0d reads.",
                 items_sent, sb.cmd_count[CMD_STEP], sb.cmd_count[CMD_SET],
                 sb.cmd_count[CMD_CLEAR], sb.cmd_count[CMD_READ]);
        $display("Checked %0d results (%0d live) under three stall mixes and a %0d-cycle hold.",
                 sb.results_seen, sb.live_seen, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.results_seen == items_sent)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
